>>> rtl/pbt_pkg.sv
// ----------------------------------------------------------------------------
// pbt_pkg: shared types and constants of the piece block tracker
// Sizes of the tracked download, command and status codes, and the packed
// request, result and internal item formats.
// ----------------------------------------------------------------------------
package pbt_pkg;

   // Geometry limits.
   localparam int MAX_PIECES  = 1024;
   localparam int MAX_BLOCKS  = 64;
   localparam int BLOCK_BYTES = 16384;

   localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int PIECE_W     = $clog2(MAX_PIECES);
   localparam int LANES       = 32;
   localparam int LANE_W      = $clog2(LANES);
   localparam int WORDS       = MAX_PIECES / LANES;
   localparam int WORD_W      = PIECE_W - LANE_W;
   localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
   localparam int BLK_W       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   // Field widths of the external interface.
   localparam int NUM_W    = 11;
   localparam int LEN_W    = 21;
   localparam int OFFS_W   = 20;
   localparam int CSR_W    = 21;
   localparam int CSR_IX_W = 2;

   typedef enum logic [1:0] {
      CMD_BLOCK     = 2'd0,
      CMD_VERDICT   = 2'd1,
      CMD_SELECT    = 2'd2,
      CMD_LOAD_PEER = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PENDING  = 3'd0,
      ST_REJECTED = 3'd1,
      ST_ALREADY  = 3'd2,
      ST_FULL     = 3'd3,
      ST_VERIFIED = 3'd4,
      ST_FAILED   = 3'd5,
      ST_SELECTED = 3'd6,
      ST_NONE     = 3'd7
   } status_type;

   typedef enum logic [CSR_IX_W-1:0] {
      CSR_NUM_PIECES = 2'd0,
      CSR_PIECE_LEN  = 2'd1,
      CSR_LAST_LEN   = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [PIECE_W-1:0] piece_index;
      logic [OFFS_W-1:0]  begin_offset;
      logic [LEN_W-1:0]   block_length;
      logic               hash_ok;
      logic               use_peer_filter;
      logic [NUM_W-1:0]   peer_piece_count;
      logic [31:0]        peer_word;
      logic [4:0]         peer_word_index;
   } pbt_req_type;

   typedef struct packed {
      status_type         status;
      logic [PIECE_W-1:0] selected_piece;
      logic [NUM_W-1:0]   completed_count;
      logic               all_complete;
   } pbt_rsp_type;

   // Configuration as seen by the front and back parts.
   typedef struct packed {
      logic [NUM_W-1:0] eff_pieces;
      logic [LEN_W-1:0] body_len;
      logic [LEN_W-1:0] tail_len;
   } pbt_cfg_type;

   // A request after classification by the front part.
   typedef struct packed {
      cmd_type            command;
      logic [PIECE_W-1:0] piece_index;
      logic               idx_bad;
      logic               range_bad;
      logic [BLK_W-1:0]   blk;
      logic               blk_ok;
      logic [CNT_W-1:0]   nblocks;
      logic               hash_ok;
      logic               use_peer_filter;
      logic [NUM_W-1:0]   peer_piece_count;
      logic [31:0]        peer_word;
      logic [4:0]         peer_word_index;
   } pbt_item_type;

   // Per-piece block record kept in memory.
   typedef struct packed {
      logic [MAX_BLOCKS-1:0] seen;
      logic [CNT_W-1:0]      cnt;
   } pbt_entry_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

endpackage

>>> rtl/pbt_ram.sv
// ----------------------------------------------------------------------------
// pbt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/pbt_front.sv
// ----------------------------------------------------------------------------
// pbt_front: request intake and classification
// Works out piece geometry, range and block checks for each request and
// holds the classified requests in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module pbt_front import pbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  pbt_req_type  req_data,
   input  pbt_cfg_type  cfg,
   output logic         item_valid,
   output pbt_item_type item,
   input  logic         item_pop
);

   pbt_item_type q_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;

   pbt_item_type       cls;
   logic               is_last;
   logic [LEN_W-1:0]   plen;
   logic [LEN_W:0]     nb_raw;
   logic [LEN_W:0]     span;
   logic [OFFS_W-1:0]  begin_blk;
   logic               push_ok;
   logic               pop_ok;

   // Geometry of the addressed piece and the checks on the arriving block.
   always_comb begin
      is_last   = (NUM_W'(req_data.piece_index) + NUM_W'(1)) == cfg.eff_pieces;
      plen      = is_last ? cfg.tail_len : cfg.body_len;
      nb_raw    = ((LEN_W+1)'(plen) + (LEN_W+1)'(BLOCK_BYTES - 1)) >> BLOCK_SHIFT;
      span      = (LEN_W+1)'(req_data.begin_offset) + (LEN_W+1)'(req_data.block_length);
      begin_blk = req_data.begin_offset >> BLOCK_SHIFT;

      cls.command          = cmd_type'(req_data.command);
      cls.piece_index      = req_data.piece_index;
      cls.idx_bad          = NUM_W'(req_data.piece_index) >= cfg.eff_pieces;
      cls.range_bad        = span > (LEN_W+1)'(plen);
      cls.nblocks          = (nb_raw > (LEN_W+1)'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                : CNT_W'(nb_raw);
      cls.blk              = BLK_W'(begin_blk);
      cls.blk_ok           = begin_blk < OFFS_W'(cls.nblocks);
      cls.hash_ok          = req_data.hash_ok;
      cls.use_peer_filter  = req_data.use_peer_filter;
      cls.peer_piece_count = req_data.peer_piece_count;
      cls.peer_word        = req_data.peer_word;
      cls.peer_word_index  = req_data.peer_word_index;
   end

   // Queue pointers and fill count.
   always_comb begin
      req_full   = cnt_ff == 2'd2;
      item_valid = cnt_ff != 2'd0;
      item       = q_ff[rd_ptr_ff];
      push_ok    = req_push && !req_full;
      pop_ok     = item_pop && item_valid;
      wr_ptr_in  = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in     = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> rtl/pbt_back.sv
// ----------------------------------------------------------------------------
// pbt_back: command execution
// Applies classified requests to the piece state, scans for the lowest
// needed piece, and queues the results.
// ----------------------------------------------------------------------------
module pbt_back import pbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  pbt_item_type     item,
   output logic             item_pop,
   input  logic [NUM_W-1:0] eff_pieces,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pbt_rsp_type      rsp_data
);

   state_type          state_ff, state_in;
   pbt_item_type       cur_ff, cur_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [NUM_W-1:0]   done_ff, done_in;
   logic [LANES-1:0]   empty_ff [WORDS];
   logic [LANES-1:0]   compl_ff [WORDS];
   logic [LANES-1:0]   peer_ff  [WORDS];

   pbt_rsp_type        rq_ff [2];
   logic               rq_wr_ff, rq_rd_ff;
   logic [1:0]         rq_cnt_ff, rq_cnt_in;

   pbt_entry_type      ram_rdata, old_ent, new_ent;
   logic               ram_we;
   logic               start;
   logic [WORD_W-1:0]  cw;
   logic [LANE_W-1:0]  cl;
   logic               p_empty, p_compl;
   logic               empty_set, empty_clr, compl_set, peer_we;
   logic               push;
   status_type         push_status;
   logic [PIECE_W-1:0] push_sel;
   logic [LANES-1:0]   elig;
   logic [LANE_W-1:0]  enc;
   logic [NUM_W-1:0]   lane_piece;

   pbt_ram #(
      .WIDTH ($bits(pbt_entry_type)),
      .DEPTH (MAX_PIECES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_ff.piece_index),
      .wr_data (new_ent),
      .rd_addr (item.piece_index),
      .rd_data (ram_rdata)
   );

   // Eligible lanes of the scanned word and the lowest of them.
   always_comb begin
      elig = '0;
      enc  = '0;
      for (int j = 0; j < LANES; j++) begin
         lane_piece = NUM_W'({word_ff, LANE_W'(j)});
         elig[j] = empty_ff[word_ff][j] && (lane_piece < eff_pieces) &&
                   !(cur_ff.use_peer_filter && (lane_piece < cur_ff.peer_piece_count) &&
                     !peer_ff[word_ff][LANES-1-j]);
      end
      for (int j = LANES - 1; j >= 0; j--) begin
         if (elig[j]) begin
            enc = LANE_W'(j);
         end
      end
   end

   // Sequencer: take a request, execute it, queue one result.
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      word_in     = word_ff;
      done_in     = done_ff;
      start       = (state_ff == S_IDLE) && item_valid && (rq_cnt_ff != 2'd2);
      item_pop    = start;
      cw          = cur_ff.piece_index[PIECE_W-1:LANE_W];
      cl          = cur_ff.piece_index[LANE_W-1:0];
      p_empty     = empty_ff[cw][cl];
      p_compl     = compl_ff[cw][cl];
      old_ent     = p_empty ? '0 : ram_rdata;
      new_ent     = old_ent;
      ram_we      = 1'b0;
      empty_set   = 1'b0;
      empty_clr   = 1'b0;
      compl_set   = 1'b0;
      peer_we     = 1'b0;
      push        = 1'b0;
      push_status = ST_PENDING;
      push_sel    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cur_in = item;
               if (item.command == CMD_LOAD_PEER) begin
                  peer_we = 1'b1;
                  push    = 1'b1;
               end else if (item.command == CMD_SELECT) begin
                  word_in  = '0;
                  state_in = S_SCAN;
               end else if (item.idx_bad) begin
                  push        = 1'b1;
                  push_status = ST_REJECTED;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            push     = 1'b1;
            if (p_compl) begin
               push_status = ST_ALREADY;
            end else if (cur_ff.command == CMD_BLOCK) begin
               // A block turns the piece active, then records itself once.
               empty_clr = 1'b1;
               ram_we    = 1'b1;
               if (!cur_ff.range_bad && cur_ff.blk_ok && !old_ent.seen[cur_ff.blk]) begin
                  new_ent.seen[cur_ff.blk] = 1'b1;
                  new_ent.cnt = old_ent.cnt + CNT_W'(1);
               end
               if (cur_ff.range_bad) begin
                  push_status = ST_REJECTED;
               end else if (new_ent.cnt < cur_ff.nblocks) begin
                  push_status = ST_PENDING;
               end else begin
                  push_status = ST_FULL;
               end
            end else if (p_empty || (old_ent.cnt < cur_ff.nblocks)) begin
               push_status = ST_REJECTED;
            end else if (cur_ff.hash_ok) begin
               compl_set   = 1'b1;
               done_in     = done_ff + NUM_W'(1);
               push_status = ST_VERIFIED;
            end else begin
               // An empty piece reads as cleared, so no memory write is needed.
               empty_set   = 1'b1;
               push_status = ST_FAILED;
            end
         end
         S_SCAN: begin
            if (elig != '0) begin
               push        = 1'b1;
               push_status = ST_SELECTED;
               push_sel    = {word_ff, enc};
               state_in    = S_IDLE;
            end else if (word_ff == WORD_W'(WORDS - 1)) begin
               push        = 1'b1;
               push_status = ST_NONE;
               state_in    = S_IDLE;
            end else begin
               word_in = word_ff + WORD_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers and piece phase bitmaps.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= '0;
         for (int w = 0; w < WORDS; w++) begin
            empty_ff[w] <= '1;
            compl_ff[w] <= '0;
            peer_ff[w]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         if (empty_set) begin
            empty_ff[cw][cl] <= 1'b1;
         end
         if (empty_clr) begin
            empty_ff[cw][cl] <= 1'b0;
         end
         if (compl_set) begin
            compl_ff[cw][cl] <= 1'b1;
         end
         if (peer_we) begin
            peer_ff[WORD_W'(item.peer_word_index)] <= item.peer_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      word_ff <= word_in;
   end

   // Result queue.
   always_comb begin
      rsp_empty = rq_cnt_ff == 2'd0;
      rsp_data  = rq_ff[rq_rd_ff];
      rq_cnt_in = rq_cnt_ff + 2'(push) - 2'(rsp_pop && !rsp_empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= 2'd0;
      end else begin
         rq_cnt_ff <= rq_cnt_in;
         if (push) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (rsp_pop && !rsp_empty) begin
            rq_rd_ff <= !rq_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rq_ff[rq_wr_ff] <= '{status:          push_status,
                              selected_piece:  push_sel,
                              completed_count: done_in,
                              all_complete:    done_in == eff_pieces};
      end
   end

endmodule

>>> rtl/piece_block_tracker.sv
// ----------------------------------------------------------------------------
// piece_block_tracker: piece and block download progress tracker
// Each request yields one result. A request waits in the intake queue;
// the back part then answers a peer word load or a bad piece index straight
// from its idle state, handles a block arrival or hash verdict in two steps
// (one read of the per-piece block memory, one update), and handles a select
// by scanning the needed-piece bitmap one 32-piece word a cycle, stopping
// at the first eligible piece. Piece state is ready right after reset.
// Results wait in a two-entry queue, so the intake keeps accepting while a
// result is not yet popped, until the queues fill.
// ----------------------------------------------------------------------------
module piece_block_tracker import pbt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  pbt_req_type         req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output pbt_rsp_type         rsp_data,
   input  logic                csr_wen,
   input  logic [CSR_IX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   logic [NUM_W-1:0] num_pieces_ff;
   logic [LEN_W-1:0] body_len_ff;
   logic [LEN_W-1:0] last_length_ff;
   pbt_cfg_type      cfg;
   logic             item_valid;
   logic             item_pop;
   pbt_item_type     item;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_pieces_ff  <= NUM_W'(1);
         body_len_ff    <= LEN_W'(262144);
         last_length_ff <= LEN_W'(262144);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_NUM_PIECES: num_pieces_ff  <= csr_wdata[NUM_W-1:0];
            CSR_PIECE_LEN:  body_len_ff    <= csr_wdata[LEN_W-1:0];
            CSR_LAST_LEN:   last_length_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Piece count saturated to the tracked maximum.
   always_comb begin
      cfg.eff_pieces = (num_pieces_ff > NUM_W'(MAX_PIECES)) ? NUM_W'(MAX_PIECES)
                                                            : num_pieces_ff;
      cfg.body_len = body_len_ff;
      cfg.tail_len = last_length_ff;
   end

   pbt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   pbt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .eff_pieces (cfg.eff_pieces),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // Only a select result carries a piece number.
   a_sel_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status != ST_SELECTED) |-> rsp_data.selected_piece == '0)
      else $error("non-select result carries a piece number");

   // A selected piece lies inside the download.
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.status == ST_SELECTED)
         |-> NUM_W'(rsp_data.selected_piece) < cfg.eff_pieces)
      else $error("selected piece beyond piece count");

   // The completion flag agrees with the completed count.
   a_all_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.all_complete == (rsp_data.completed_count == cfg.eff_pieces)))
      else $error("completion flag disagrees with count");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the piece block tracker
// A directed table covers reset values, index and range errors, verdicts and
// selection corners; random traffic then runs whole pieces through download,
// verdict and selection under several geometries. Every result is compared
// with a behavioral tracker model kept in this bench.
// ----------------------------------------------------------------------------
module tb;
   import pbt_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   pbt_req_type         req_data;
   logic                rsp_empty;
   logic                rsp_pop;
   pbt_rsp_type         rsp_data;
   logic                csr_wen;
   logic [CSR_IX_W-1:0] csr_index;
   logic [CSR_W-1:0]    csr_wdata;

   piece_block_tracker uut (.*);

   // Clock with a 10 unit period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Model state of the tracker.
   logic [1:0]            mdl_phase [MAX_PIECES];
   logic [MAX_BLOCKS-1:0] mdl_seen [MAX_PIECES];
   int unsigned           mdl_count [MAX_PIECES];
   logic [31:0]           mdl_peer [WORDS];
   int unsigned           mdl_done;
   int unsigned           cfg_num;
   int unsigned           cfg_plen;
   int unsigned           cfg_last;

   localparam logic [1:0] PH_EMPTY    = 2'd0;
   localparam logic [1:0] PH_ACTIVE   = 2'd1;
   localparam logic [1:0] PH_COMPLETE = 2'd2;

   // Expected results and a per-row "typed-in" status check.
   pbt_rsp_type expected_rsp [$];
   int          typed_status [$];
   int          mismatches;
   int          cycles;
   logic        timed_out;

   localparam int CYCLE_LIMIT = 400000;

   function automatic int unsigned eff_pieces();
      return (cfg_num > MAX_PIECES) ? MAX_PIECES : cfg_num;
   endfunction

   function automatic int unsigned piece_bytes(int unsigned idx);
      return (idx + 1 == eff_pieces()) ? cfg_last : cfg_plen;
   endfunction

   function automatic int unsigned piece_blocks(int unsigned idx);
      int unsigned n;
      n = (piece_bytes(idx) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
   endfunction

   function automatic void model_reset();
      for (int i = 0; i < MAX_PIECES; i++) begin
         mdl_phase[i] = PH_EMPTY;
         mdl_seen[i] = '0;
         mdl_count[i] = 0;
      end
      for (int w = 0; w < WORDS; w++) mdl_peer[w] = '0;
      mdl_done = 0;
      cfg_num = 1;
      cfg_plen = 262144;
      cfg_last = 262144;
   endfunction

   // Advance the tracker model by one request and return its result.
   function automatic pbt_rsp_type track_request(pbt_req_type rq);
      pbt_rsp_type r;
      status_type  st;
      int unsigned idx, nb, blk;
      logic        found;
      st = ST_PENDING;
      idx = 32'(rq.piece_index);
      r = '0;
      case (cmd_type'(rq.command))
         CMD_BLOCK: begin
            if (idx >= eff_pieces()) st = ST_REJECTED;
            else if (mdl_phase[idx] == PH_COMPLETE) st = ST_ALREADY;
            else begin
               mdl_phase[idx] = PH_ACTIVE;
               if (rq.begin_offset + rq.block_length > piece_bytes(idx)) begin
                  st = ST_REJECTED;
               end else begin
                  nb = piece_blocks(idx);
                  blk = rq.begin_offset / BLOCK_BYTES;
                  if (blk < nb && !mdl_seen[idx][blk]) begin
                     mdl_seen[idx][blk] = 1'b1;
                     mdl_count[idx]++;
                  end
                  st = (mdl_count[idx] < nb) ? ST_PENDING : ST_FULL;
               end
            end
         end
         CMD_VERDICT: begin
            if (idx >= eff_pieces()) st = ST_REJECTED;
            else if (mdl_phase[idx] == PH_COMPLETE) st = ST_ALREADY;
            else if (mdl_phase[idx] != PH_ACTIVE || mdl_count[idx] < piece_blocks(idx))
               st = ST_REJECTED;
            else if (rq.hash_ok) begin
               mdl_phase[idx] = PH_COMPLETE;
               mdl_done++;
               st = ST_VERIFIED;
            end else begin
               mdl_phase[idx] = PH_EMPTY;
               mdl_seen[idx] = '0;
               mdl_count[idx] = 0;
               st = ST_FAILED;
            end
         end
         CMD_SELECT: begin
            found = 1'b0;
            for (int i = 0; i < eff_pieces() && !found; i++) begin
               if (mdl_phase[i] == PH_EMPTY &&
                   !(rq.use_peer_filter && i < rq.peer_piece_count &&
                     !mdl_peer[i / 32][31 - (i % 32)])) begin
                  found = 1'b1;
                  r.selected_piece = PIECE_W'(i);
               end
            end
            st = found ? ST_SELECTED : ST_NONE;
         end
         default: begin
            if (rq.peer_word_index < WORDS) mdl_peer[rq.peer_word_index] = rq.peer_word;
            st = ST_PENDING;
         end
      endcase
      r.status = st;
      r.completed_count = NUM_W'(mdl_done);
      r.all_complete = (mdl_done == eff_pieces());
      return r;
   endfunction

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT && !timed_out) begin
         timed_out <= 1'b1;
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random pop gaps, compare on every accepted result.
   int pop_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_gap = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               pbt_rsp_type e;
               int          ts;
               e = expected_rsp.pop_front();
               ts = typed_status.pop_front();
               if (rsp_data !== e || (ts >= 0 && rsp_data.status != status_type'(ts))) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p (status %0d), got %p", e, ts, rsp_data);
               end
            end
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            case ($urandom_range(0, 9))
               0, 1: pop_gap = $urandom_range(1, 3);
               2:    pop_gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : 0;
               default: pop_gap = 0;
            endcase
         end
      end
   end

   // Send one request; the push stays high until accepted.
   int push_gap_mode;
   task automatic send_request(pbt_req_type rq, int typed);
      int gap;
      gap = 0;
      if (push_gap_mode != 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : 0;
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_full) @(posedge clock);
      expected_rsp.push_back(track_request(rq));
      typed_status.push_back(typed);
   endtask

   task automatic go_idle();
      req_push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type ix, int unsigned value);
      csr_wen <= 1'b1;
      csr_index <= ix;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
      csr_wen <= 1'b0;
      case (ix)
         CSR_NUM_PIECES: cfg_num = value & 32'h7FF;
         CSR_PIECE_LEN:  cfg_plen = value & 32'h1FFFFF;
         CSR_LAST_LEN:   cfg_last = value & 32'h1FFFFF;
         default: ;
      endcase
   endtask

   function automatic pbt_req_type make_req(cmd_type c, int unsigned idx,
                                            int unsigned offs, int unsigned len);
      pbt_req_type rq;
      rq = '0;
      rq.command = c;
      rq.piece_index = PIECE_W'(idx);
      rq.begin_offset = OFFS_W'(offs);
      rq.block_length = LEN_W'(len);
      rq.hash_ok = 1'b1;
      return rq;
   endfunction

   // Random content in every field, the command included; callers force fields afterwards.
   function automatic pbt_req_type noise_req();
      pbt_req_type rq;
      rq.command = 2'($urandom_range(0, 3));
      rq.piece_index = PIECE_W'($urandom);
      rq.begin_offset = OFFS_W'($urandom);
      rq.block_length = LEN_W'($urandom_range(0, 1048576));
      rq.hash_ok = 1'($urandom);
      rq.use_peer_filter = 1'($urandom);
      rq.peer_piece_count = NUM_W'($urandom_range(0, 1024));
      rq.peer_word = $urandom;
      rq.peer_word_index = 5'($urandom);
      return rq;
   endfunction

   // Directed table: request plus typed-in status, -1 where the model decides.
   typedef struct {
      pbt_req_type rq;
      int          st;
   } dir_row_type;

   task automatic run_directed();
      dir_row_type rows [$];
      pbt_req_type rq;
      // Reset geometry: one piece of 16 blocks.
      rows.push_back('{make_req(CMD_SELECT, 0, 0, 0), ST_SELECTED});
      rows.push_back('{make_req(CMD_BLOCK, 1023, 0, 16384), ST_REJECTED});
      rows.push_back('{make_req(CMD_VERDICT, 1, 0, 0), ST_REJECTED});
      rows.push_back('{make_req(CMD_VERDICT, 0, 0, 0), ST_REJECTED});
      rows.push_back('{make_req(CMD_BLOCK, 0, 1048575, 1048576), ST_REJECTED});
      rows.push_back('{make_req(CMD_SELECT, 0, 0, 0), ST_NONE});
      rows.push_back('{make_req(CMD_BLOCK, 0, 0, 16384), ST_PENDING});
      rows.push_back('{make_req(CMD_BLOCK, 0, 0, 16384), ST_PENDING});
      rows.push_back('{make_req(CMD_VERDICT, 0, 0, 0), ST_REJECTED});
      for (int b = 1; b < 16; b++)
         rows.push_back('{make_req(CMD_BLOCK, 0, b * 16384, 16384), (b == 15) ? ST_FULL : -1});
      rq = make_req(CMD_VERDICT, 0, 0, 0);
      rq.hash_ok = 1'b0;
      rows.push_back('{rq, ST_FAILED});
      rq = make_req(CMD_LOAD_PEER, 0, 0, 0);
      rq.peer_word = 32'h0;
      rq.peer_word_index = 5'd31;
      rows.push_back('{rq, ST_PENDING});
      rq = make_req(CMD_SELECT, 0, 0, 0);
      rq.use_peer_filter = 1'b1;
      rq.peer_piece_count = 11'd1024;
      rows.push_back('{rq, ST_NONE});
      rq.peer_piece_count = 11'd0;
      rows.push_back('{rq, ST_SELECTED});
      foreach (rows[i]) send_request(rows[i].rq, rows[i].st);
      go_idle();
   endtask

   // Random phase under one geometry.
   task automatic run_random(int unsigned n_items);
      pbt_req_type rq;
      int unsigned np, idx, nb;
      np = eff_pieces();
      for (int k = 0; k < n_items; k++) begin
         idx = (np == 0) ? $urandom_range(0, 3) : $urandom_range(0, np - 1);
         case ($urandom_range(0, 19))
            0, 1: rq = noise_req();
            2, 3, 4: begin
               rq = noise_req();
               rq.command = CMD_VERDICT;
               rq.piece_index = PIECE_W'(idx);
               rq.hash_ok = ($urandom_range(0, 3) != 0);
            end
            5, 6: begin
               rq = noise_req();
               rq.command = CMD_SELECT;
               if ($urandom_range(0, 1))
                  rq.peer_piece_count = NUM_W'($urandom_range(0, np + 2));
            end
            7: begin
               rq = noise_req();
               rq.command = CMD_LOAD_PEER;
               if ($urandom_range(0, 2) == 0) rq.peer_word = 32'hFFFFFFFF;
            end
            8: begin
               rq = noise_req();
               rq.command = CMD_BLOCK;
               rq.piece_index = PIECE_W'(idx);
               rq.begin_offset = OFFS_W'($urandom_range(0, piece_bytes(idx)));
               rq.block_length = LEN_W'($urandom_range(0, 20000));
            end
            default: begin
               // A well-formed block of an existing piece.
               nb = (np == 0) ? 1 : piece_blocks(idx);
               rq = noise_req();
               rq.command = CMD_BLOCK;
               rq.piece_index = PIECE_W'(idx);
               rq.begin_offset = (nb == 0) ? '0 :
                  OFFS_W'($urandom_range(0, nb - 1) * BLOCK_BYTES);
               rq.block_length = (nb == 0) ? '0 :
                  LEN_W'((rq.begin_offset + BLOCK_BYTES > piece_bytes(idx)) ?
                         piece_bytes(idx) - rq.begin_offset : BLOCK_BYTES);
            end
         endcase
         push_gap_mode = (k % 200 < 150);
         send_request(rq, -1);
      end
      go_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_wen = 1'b0;
      csr_index = CSR_NUM_PIECES;
      csr_wdata = '0;
      mismatches = 0;
      cycles = 0;
      timed_out = 1'b0;
      push_gap_mode = 1;
      model_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(100);

      // Small pieces of three blocks, short last piece.
      write_csr(CSR_NUM_PIECES, 6);
      write_csr(CSR_PIECE_LEN, 40000);
      write_csr(CSR_LAST_LEN, 1);
      run_random(300);

      // Zero pieces, then zero-length pieces.
      write_csr(CSR_NUM_PIECES, 0);
      run_random(40);
      write_csr(CSR_NUM_PIECES, 40);
      write_csr(CSR_PIECE_LEN, 0);
      write_csr(CSR_LAST_LEN, 16384);
      run_random(300);

      // Largest sizes: beyond the piece cap, pieces of 64 blocks.
      write_csr(CSR_NUM_PIECES, 2047);
      write_csr(CSR_PIECE_LEN, 1048576);
      write_csr(CSR_LAST_LEN, 2097151);
      run_random(120);

      // Many single-block pieces with peer filtering.
      write_csr(CSR_NUM_PIECES, 70);
      write_csr(CSR_PIECE_LEN, 1);
      write_csr(CSR_LAST_LEN, 16385);
      run_random(340);

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
